### rtl/mbrtu_pkg.sv
`default_nettype none
package mbrtu_pkg;

	localparam int MAX_REGS = 123;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [7:0]  FN_READ   = 8'h03;
	localparam logic [7:0]  FN_WRITE  = 8'h10;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Input opcodes.
	localparam logic [1:0] OP_START_RD = 2'd0;
	localparam logic [1:0] OP_START_WR = 2'd1;
	localparam logic [1:0] OP_DATA     = 2'd2;
	localparam logic [1:0] OP_RX       = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ID    = 3'd1;
	localparam logic [2:0] ST_FUNC  = 3'd2;
	localparam logic [2:0] ST_BCNT  = 3'd3;
	localparam logic [2:0] ST_ADDR  = 3'd4;
	localparam logic [2:0] ST_QTY   = 3'd5;
	localparam logic [2:0] ST_CRC   = 3'd6;

	// Transaction phases.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SEND = 2'd1;
	localparam logic [1:0] PH_RECV = 2'd2;

	typedef enum logic [2:0] {
		CMD_HDR_RD,
		CMD_HDR_WR,
		CMD_DATA,
		CMD_DATA_LAST,
		CMD_WORD,
		CMD_STATUS
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  slave;
		logic [15:0] addr;
		logic [6:0]  cnt;
		logic [15:0] word;
		logic [6:0]  index;
		logic [2:0]  status;
	} cmd_t;

	// One byte of the reflected CRC-16, eight shift steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/mbrtu_if.sv
`default_nettype none
interface mbrtu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [7:0]  slave_id;
	logic [15:0] start_address;
	logic [6:0]  register_count;
	logic [15:0] data_word;
	logic [7:0]  rx_byte;
	modport source (output valid, opcode, slave_id, start_address, register_count,
		data_word, rx_byte, input ready);
	modport sink (input valid, opcode, slave_id, start_address, register_count,
		data_word, rx_byte, output ready);
endinterface

interface mbrtu_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        frame_end;
	logic [15:0] read_word;
	logic [6:0]  word_index;
	logic [2:0]  status;
	logic        run_last;
	modport source (output valid, kind, tx_byte, frame_end, read_word, word_index,
		status, run_last, input ready);
	modport sink (input valid, kind, tx_byte, frame_end, read_word, word_index,
		status, run_last, output ready);
endinterface
`default_nettype wire

### rtl/mbrtu_front.sv
`default_nettype none
module mbrtu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mbrtu_req_if.sink          req,
	input  wire logic          q_full,
	output mbrtu_pkg::cmd_t    q_cmd,
	output logic               q_push
);
	import mbrtu_pkg::*;

	logic [1:0]  phase_q;
	logic        is_write_q;
	logic [7:0]  held_slave_q;
	logic [15:0] held_address_q;
	logic [6:0]  held_count_q;
	logic [6:0]  words_done_q;
	logic [15:0] rx_crc_q;
	logic [7:0]  rx_pos_q;
	logic [2:0]  first_error_q;
	logic [7:0]  pending_q;

	logic [1:0]  phase_d;
	logic        is_write_d;
	logic [7:0]  held_slave_d;
	logic [15:0] held_address_d;
	logic [6:0]  held_count_d;
	logic [6:0]  words_done_d;
	logic [15:0] rx_crc_d;
	logic [7:0]  rx_pos_d;
	logic [2:0]  first_error_d;
	logic [7:0]  pending_d;

	logic        accept;
	logic        cmd_vld;
	logic [6:0]  cnt_sat;
	logic [6:0]  wd_inc;
	logic [7:0]  rx_len;
	logic [7:0]  pos_m4;
	logic [2:0]  err;
	logic [15:0] pair;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;
	assign q_push    = accept && cmd_vld;

	always_comb begin
		if (req.register_count == 7'd0) begin
			cnt_sat = 7'd1;
		end else if (req.register_count > 7'(MAX_REGS)) begin
			cnt_sat = 7'(MAX_REGS);
		end else begin
			cnt_sat = req.register_count;
		end
	end

	assign wd_inc = words_done_q + 7'd1;
	assign rx_len = is_write_q ? 8'd8 : ({1'b0, held_count_q} << 1) + 8'd5;
	assign pos_m4 = rx_pos_q - 8'd4;
	assign pair   = {pending_q, req.rx_byte};

	always_comb begin
		phase_d        = phase_q;
		is_write_d     = is_write_q;
		held_slave_d   = held_slave_q;
		held_address_d = held_address_q;
		held_count_d   = held_count_q;
		words_done_d   = words_done_q;
		rx_crc_d       = rx_crc_q;
		rx_pos_d       = rx_pos_q;
		first_error_d  = first_error_q;
		pending_d      = pending_q;
		err            = ST_OK;
		cmd_vld        = 1'b0;
		q_cmd          = '0;
		q_cmd.slave    = req.slave_id;
		q_cmd.addr     = req.start_address;
		q_cmd.cnt      = cnt_sat;
		q_cmd.word     = req.data_word;
		case (req.opcode)
			OP_START_RD, OP_START_WR: begin
				cmd_vld        = 1'b1;
				held_slave_d   = req.slave_id;
				held_address_d = req.start_address;
				held_count_d   = cnt_sat;
				words_done_d   = 7'd0;
				is_write_d     = (req.opcode == OP_START_WR);
				if (req.opcode == OP_START_WR) begin
					q_cmd.op = CMD_HDR_WR;
					phase_d  = PH_SEND;
				end else begin
					q_cmd.op      = CMD_HDR_RD;
					phase_d       = PH_RECV;
					rx_crc_d      = CRC_INIT;
					rx_pos_d      = 8'd0;
					first_error_d = ST_OK;
					pending_d     = 8'd0;
				end
			end
			OP_DATA: begin
				if (phase_q == PH_SEND) begin
					cmd_vld      = 1'b1;
					words_done_d = wd_inc;
					if (wd_inc >= held_count_q) begin
						q_cmd.op      = CMD_DATA_LAST;
						phase_d       = PH_RECV;
						rx_crc_d      = CRC_INIT;
						rx_pos_d      = 8'd0;
						first_error_d = ST_OK;
						pending_d     = 8'd0;
					end else begin
						q_cmd.op = CMD_DATA;
					end
				end
			end
			default: begin
				if (phase_q == PH_RECV) begin
					if (rx_pos_q < rx_len - 8'd2) begin
						rx_crc_d = crc_byte(rx_crc_q, req.rx_byte);
					end
					if (rx_pos_q == rx_len - 8'd1) begin
						if ({req.rx_byte, pending_q} != rx_crc_q) begin
							err = ST_CRC;
						end
					end else if (rx_pos_q == rx_len - 8'd2) begin
						pending_d = req.rx_byte;
					end else if (rx_pos_q == 8'd0) begin
						if (req.rx_byte != held_slave_q) begin
							err = ST_ID;
						end
					end else if (rx_pos_q == 8'd1) begin
						if (req.rx_byte != (is_write_q ? FN_WRITE : FN_READ)) begin
							err = ST_FUNC;
						end
					end else if (is_write_q) begin
						if (rx_pos_q == 8'd2 || rx_pos_q == 8'd4) begin
							pending_d = req.rx_byte;
						end else if (rx_pos_q == 8'd3) begin
							if (pair != held_address_q) begin
								err = ST_ADDR;
							end
						end else if (pair != {9'd0, held_count_q}) begin
							err = ST_QTY;
						end
					end else begin
						if (rx_pos_q == 8'd2) begin
							if (req.rx_byte != {held_count_q, 1'b0}) begin
								err = ST_BCNT;
							end
						end else if (rx_pos_q[0]) begin
							// Odd offsets past the byte count hold the high byte.
							pending_d = req.rx_byte;
						end else begin
							cmd_vld     = 1'b1;
							q_cmd.op    = CMD_WORD;
							q_cmd.word  = pair;
							q_cmd.index = pos_m4[7:1];
						end
					end
					if (err != ST_OK && first_error_q == ST_OK) begin
						first_error_d = err;
					end
					rx_pos_d = rx_pos_q + 8'd1;
					if (rx_pos_q == rx_len - 8'd1) begin
						cmd_vld      = 1'b1;
						q_cmd.op     = CMD_STATUS;
						q_cmd.status = first_error_d;
						phase_d      = PH_IDLE;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			is_write_q     <= 1'b0;
			held_slave_q   <= '0;
			held_address_q <= '0;
			held_count_q   <= '0;
			words_done_q   <= '0;
			rx_crc_q       <= CRC_INIT;
			rx_pos_q       <= '0;
			first_error_q  <= ST_OK;
			pending_q      <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			is_write_q     <= is_write_d;
			held_slave_q   <= held_slave_d;
			held_address_q <= held_address_d;
			held_count_q   <= held_count_d;
			words_done_q   <= words_done_d;
			rx_crc_q       <= rx_crc_d;
			rx_pos_q       <= rx_pos_d;
			first_error_q  <= first_error_d;
			pending_q      <= pending_d;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("push into full queue");
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3) else $error("unused phase reached");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (held_count_q != 7'd0 && held_count_q <= 7'(MAX_REGS)))
		else $error("held count out of range");

endmodule
`default_nettype wire

### rtl/mbrtu_queue.sv
`default_nettype none
module mbrtu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  mbrtu_pkg::cmd_t    push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               head_vld,
	output mbrtu_pkg::cmd_t    head_cmd
);
	import mbrtu_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_vld = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count overflow");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointers disagree");

endmodule
`default_nettype wire

### rtl/mbrtu_back.sv
`default_nettype none
module mbrtu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_vld,
	input  mbrtu_pkg::cmd_t    head_cmd,
	output logic               pop,
	mbrtu_rsp_if.source        rsp
);
	import mbrtu_pkg::*;

	logic [2:0]  idx_q;
	logic [15:0] tx_crc_q;
	logic        out_vld_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_byte_q;
	logic        frame_end_q;
	logic [15:0] read_word_q;
	logic [6:0]  word_index_q;
	logic [2:0]  status_q;
	logic        run_last_q;

	logic        load;
	logic        last_beat;
	logic        crc_upd;
	logic [15:0] crc_base;
	logic [1:0]  kind_d;
	logic [7:0]  byte_d;
	logic        fe_d;

	assign load = head_vld && (!out_vld_q || rsp.ready);
	assign pop  = load && last_beat;

	always_comb begin
		last_beat = 1'b0;
		crc_upd   = 1'b0;
		kind_d    = KIND_TX;
		byte_d    = 8'h00;
		fe_d      = 1'b0;
		crc_base  = (idx_q == 3'd0) ? CRC_INIT : tx_crc_q;
		case (head_cmd.op)
			CMD_HDR_RD, CMD_HDR_WR: begin
				crc_upd = 1'b1;
				case (idx_q)
					3'd0: byte_d = head_cmd.slave;
					3'd1: byte_d = (head_cmd.op == CMD_HDR_WR) ? FN_WRITE : FN_READ;
					3'd2: byte_d = head_cmd.addr[15:8];
					3'd3: byte_d = head_cmd.addr[7:0];
					3'd4: byte_d = 8'h00;
					3'd5: byte_d = {1'b0, head_cmd.cnt};
					3'd6: begin
						if (head_cmd.op == CMD_HDR_WR) begin
							byte_d    = {head_cmd.cnt, 1'b0};
							last_beat = 1'b1;
						end else begin
							byte_d  = tx_crc_q[7:0];
							crc_upd = 1'b0;
						end
					end
					default: begin
						byte_d    = tx_crc_q[15:8];
						crc_upd   = 1'b0;
						fe_d      = 1'b1;
						last_beat = 1'b1;
					end
				endcase
			end
			CMD_DATA, CMD_DATA_LAST: begin
				crc_base = tx_crc_q;
				case (idx_q)
					3'd0: begin
						byte_d  = head_cmd.word[15:8];
						crc_upd = 1'b1;
					end
					3'd1: begin
						byte_d    = head_cmd.word[7:0];
						crc_upd   = 1'b1;
						last_beat = (head_cmd.op == CMD_DATA);
					end
					3'd2: byte_d = tx_crc_q[7:0];
					default: begin
						byte_d    = tx_crc_q[15:8];
						fe_d      = 1'b1;
						last_beat = 1'b1;
					end
				endcase
			end
			CMD_WORD: begin
				kind_d    = KIND_WORD;
				last_beat = 1'b1;
			end
			default: begin
				kind_d    = KIND_STATUS;
				last_beat = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			tx_crc_q  <= CRC_INIT;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q     <= last_beat ? 3'd0 : idx_q + 3'd1;
				out_vld_q <= 1'b1;
				if (crc_upd) begin
					tx_crc_q <= crc_byte(crc_base, byte_d);
				end
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q       <= kind_d;
			tx_byte_q    <= byte_d;
			frame_end_q  <= fe_d;
			read_word_q  <= (kind_d == KIND_WORD) ? head_cmd.word : 16'h0000;
			word_index_q <= (kind_d == KIND_WORD) ? head_cmd.index : 7'd0;
			status_q     <= (kind_d == KIND_STATUS) ? head_cmd.status : ST_OK;
			run_last_q   <= last_beat;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.kind       = kind_q;
	assign rsp.tx_byte    = tx_byte_q;
	assign rsp.frame_end  = frame_end_q;
	assign rsp.read_word  = read_word_q;
	assign rsp.word_index = word_index_q;
	assign rsp.status     = status_q;
	assign rsp.run_last   = run_last_q;

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && kind_q == KIND_STATUS) |-> run_last_q)
		else $error("status beat not last");
	a_fe_is_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && frame_end_q) |-> (kind_q == KIND_TX && run_last_q))
		else $error("frame end on wrong beat");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(head_vld && (head_cmd.op == CMD_DATA || head_cmd.op == CMD_DATA_LAST)) |-> idx_q < 3'd4)
		else $error("data beat counter out of range");

endmodule
`default_nettype wire

### rtl/modbus_rtu_master_frame_engine_unit.sv
`default_nettype none
// Modbus RTU master frame engine (read and write holding registers).
// Input channel req carries one beat per command: start read, start write,
// write data word, or one byte received from the slave. Output channel rsp
// carries result beats: frame bytes to transmit, read register words and one
// transaction status when the expected reply length has been received.
// run_last marks the final result beat caused by an input beat.
// A front stage decodes each input beat combinationally, tracks the
// transaction and checks reply bytes (slave id, function, byte count or
// echoed address and quantity, CRC). It pushes at most one command per input
// beat into a four-entry queue. The back stage expands each command into
// result beats, one beat per cycle while rsp is ready, computing the request
// CRC byte by byte as it emits frame bytes. A read request yields 8 frame
// bytes, a write header 7, a data word 2 or 4, a reply byte at most one
// result beat; inputs are taken every cycle while the queue has room. A
// stalled rsp holds its beat; the queue absorbs up to four commands before
// req.ready falls. Reset clears the control state to idle.
module modbus_rtu_master_frame_engine_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mbrtu_req_if.sink   req,
	mbrtu_rsp_if.source rsp
);
	import mbrtu_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic push;
	logic full;
	logic pop;
	logic head_vld;

	mbrtu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (full),
		.q_cmd  (push_cmd),
		.q_push (push)
	);

	mbrtu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head_vld (head_vld),
		.head_cmd (head_cmd)
	);

	mbrtu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head_cmd (head_cmd),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
	import mbrtu_pkg::*;

	// One expected result beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        frame_end;
		logic [15:0] read_word;
		logic [6:0]  word_index;
		logic [2:0]  status;
		logic        run_last;
	} beat_t;

	int err_count = 0;

	// Prints one line per mismatch and counts it.
	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Models the frame engine and holds the beats it should produce.
	class frame_scoreboard;
		logic [1:0]  phase;
		logic        is_write;
		logic [7:0]  held_slave;
		logic [15:0] held_address;
		logic [6:0]  held_count;
		logic [6:0]  words_done;
		logic [15:0] tx_crc;
		logic [15:0] rx_crc;
		logic [7:0]  rx_position;
		logic [2:0]  first_error;
		logic [7:0]  pending_byte;
		beat_t       pending_beats[$];
		beat_t       step_beats[$];

		function void clear();
			phase = PH_IDLE; is_write = 0; held_slave = 0; held_address = 0;
			held_count = 0; words_done = 0; tx_crc = CRC_INIT; rx_crc = CRC_INIT;
			rx_position = 0; first_error = 0; pending_byte = 0;
			pending_beats.delete();
		endfunction

		function logic [15:0] crc8(input logic [15:0] c, input logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void push(input logic [1:0] k, input logic [7:0] tx, input logic fe,
			input logic [15:0] rw, input logic [6:0] wi, input logic [2:0] st);
			beat_t b;
			b = '{k, tx, fe, rw, wi, st, 1'b0};
			step_beats.push_back(b);
		endfunction

		function void send(input logic [7:0] b, input logic fe);
			tx_crc = crc8(tx_crc, b);
			push(KIND_TX, b, fe, 0, 0, ST_OK);
		endfunction

		function void begin_reply();
			phase = PH_RECV; rx_crc = CRC_INIT; rx_position = 0;
			first_error = ST_OK; pending_byte = 0;
		endfunction

		// Notes one accepted input beat and queues the beats it causes.
		function void note_input(input logic [1:0] op, input logic [7:0] sid,
			input logic [15:0] addr, input logic [6:0] cnt_in, input logic [15:0] w,
			input logic [7:0] b);
			logic [6:0]  cnt;
			logic [15:0] crc;
			int          p, len;
			logic [2:0]  e;
			step_beats.delete();
			if (op == OP_START_RD || op == OP_START_WR) begin
				cnt = cnt_in;
				if (cnt < 1) cnt = 1;
				if (cnt > MAX_REGS) cnt = MAX_REGS;
				held_slave = sid; held_address = addr; held_count = cnt;
				words_done = 0; is_write = (op == OP_START_WR); tx_crc = CRC_INIT;
				send(sid, 0);
				send(is_write ? FN_WRITE : FN_READ, 0);
				send(addr[15:8], 0);
				send(addr[7:0], 0);
				send(8'h00, 0);
				send({1'b0, cnt}, 0);
				if (is_write) begin
					send({cnt, 1'b0}, 0);
					phase = PH_SEND;
				end else begin
					crc = tx_crc;
					push(KIND_TX, crc[7:0], 0, 0, 0, ST_OK);
					push(KIND_TX, crc[15:8], 1, 0, 0, ST_OK);
					begin_reply();
				end
			end else if (op == OP_DATA) begin
				if (phase == PH_SEND) begin
					send(w[15:8], 0);
					send(w[7:0], 0);
					words_done = words_done + 1;
					if (words_done >= held_count) begin
						crc = tx_crc;
						push(KIND_TX, crc[7:0], 0, 0, 0, ST_OK);
						push(KIND_TX, crc[15:8], 1, 0, 0, ST_OK);
						begin_reply();
					end
				end
			end else if (phase == PH_RECV) begin
				p = rx_position;
				len = is_write ? 8 : held_count * 2 + 5;
				e = ST_OK;
				if (p < len - 2) rx_crc = crc8(rx_crc, b);
				if (p == len - 1) begin
					if ({b, pending_byte} != rx_crc) e = ST_CRC;
				end else if (p == len - 2) pending_byte = b;
				else if (p == 0) begin
					if (b != held_slave) e = ST_ID;
				end else if (p == 1) begin
					if (b != (is_write ? FN_WRITE : FN_READ)) e = ST_FUNC;
				end else if (is_write) begin
					if (p == 2 || p == 4) pending_byte = b;
					else if (p == 3) begin
						if ({pending_byte, b} != held_address) e = ST_ADDR;
					end else if ({pending_byte, b} != {9'd0, held_count}) e = ST_QTY;
				end else begin
					if (p == 2) begin
						if (b != {held_count, 1'b0}) e = ST_BCNT;
					end else if (((p - 3) & 1) == 0) pending_byte = b;
					else push(KIND_WORD, 0, 0, {pending_byte, b}, 7'((p - 4) >> 1), ST_OK);
				end
				if (e != ST_OK && first_error == ST_OK) first_error = e;
				rx_position = rx_position + 1;
				if (p == len - 1) begin
					push(KIND_STATUS, 0, 0, 0, 0, first_error);
					phase = PH_IDLE;
				end
			end
			if (step_beats.size() > 0) step_beats[$].run_last = 1;
			foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
		endfunction

		// Checks one result beat against the oldest expectation.
		task check_result(input beat_t got);
			beat_t want;
			if (pending_beats.size() == 0) begin
				report($sformatf("unexpected beat %p", got));
				return;
			end
			want = pending_beats.pop_front();
			if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
			if (got.tx_byte != want.tx_byte)
				report($sformatf("tx_byte %h want %h", got.tx_byte, want.tx_byte));
			if (got.frame_end != want.frame_end)
				report($sformatf("frame_end %b want %b", got.frame_end, want.frame_end));
			if (got.read_word != want.read_word)
				report($sformatf("read_word %h want %h", got.read_word, want.read_word));
			if (got.word_index != want.word_index)
				report($sformatf("word_index %0d want %0d", got.word_index, want.word_index));
			if (got.status != want.status)
				report($sformatf("status %0d want %0d", got.status, want.status));
			if (got.run_last != want.run_last)
				report($sformatf("run_last %b want %b", got.run_last, want.run_last));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #6 clk = ~clk;

	mbrtu_req_if req ();
	mbrtu_rsp_if rsp ();

	modbus_rtu_master_frame_engine_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	frame_scoreboard sb = new();
	bit stim_done = 0;
	bit hold_off = 0;

	initial begin
		req.valid = 0; req.opcode = OP_START_RD; req.slave_id = 0;
		req.start_address = 0; req.register_count = 0; req.data_word = 0;
		req.rx_byte = 0; rsp.ready = 0;
	end

	// Mostly short gaps, now and then a long one, often none.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one beat and waits until the block takes it. With no gap the
	// next beat follows at once and valid stays high.
	task automatic send_item(input logic [1:0] op, input logic [7:0] sid,
		input logic [15:0] addr, input logic [6:0] cnt, input logic [15:0] w,
		input logic [7:0] b);
		int g;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1; req.opcode <= op; req.slave_id <= sid;
		req.start_address <= addr; req.register_count <= cnt;
		req.data_word <= w; req.rx_byte <= b;
		do @(posedge clk); while (!req.ready);
		sb.note_input(op, sid, addr, cnt, w, b);
	endtask

	// Reply byte, or a random byte with the given odds.
	task automatic rx(input logic [7:0] b, input int bad_pct);
		send_item(OP_RX, 8'($urandom), 16'($urandom), 7'($urandom), 16'($urandom),
			($urandom_range(0, 99) < bad_pct) ? 8'($urandom) : b);
	endtask

	function automatic logic [15:0] crc_of(input logic [7:0] bytes[$]);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (bytes[i]) c = sb.crc8(c, bytes[i]);
		return c;
	endfunction

	// A full read transaction followed by its reply.
	task automatic read_txn(input logic [7:0] sid, input logic [15:0] addr,
		input logic [6:0] cnt, input int bad_pct);
		logic [7:0]  r[$];
		logic [15:0] c;
		int          n;
		send_item(OP_START_RD, sid, addr, cnt, 16'($urandom), 8'($urandom));
		n = (cnt < 1) ? 1 : (cnt > MAX_REGS ? MAX_REGS : cnt);
		r = '{sid, FN_READ, 8'(2 * n)};
		repeat (2 * n) r.push_back(8'($urandom));
		c = crc_of(r);
		r.push_back(c[7:0]); r.push_back(c[15:8]);
		foreach (r[i]) rx(r[i], bad_pct);
	endtask

	// A full write transaction: header, data words and its echo reply.
	task automatic write_txn(input logic [7:0] sid, input logic [15:0] addr,
		input logic [6:0] cnt, input int bad_pct);
		logic [7:0]  r[$];
		logic [15:0] c;
		int          n;
		send_item(OP_START_WR, sid, addr, cnt, 16'($urandom), 8'($urandom));
		n = (cnt < 1) ? 1 : (cnt > MAX_REGS ? MAX_REGS : cnt);
		repeat (n) send_item(OP_DATA, 8'($urandom), 16'($urandom), 7'($urandom),
			16'($urandom), 8'($urandom));
		r = '{sid, FN_WRITE, addr[15:8], addr[7:0], 8'h00, 8'(n)};
		c = crc_of(r);
		r.push_back(c[7:0]); r.push_back(c[15:8]);
		foreach (r[i]) rx(r[i], bad_pct);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 0;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0 && $urandom_range(0, 2) == 0) begin
				rsp.ready <= 0;
				repeat (g) @(posedge clk);
			end
			rsp.ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result('{rsp.kind, rsp.tx_byte, rsp.frame_end, rsp.read_word,
				rsp.word_index, rsp.status, rsp.run_last});
	end

	initial begin
		int sel;
		sb.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: stray beats while idle, count extremes, errors of each kind.
		send_item(OP_DATA, 0, 0, 0, 16'hFFFF, 0);
		send_item(OP_RX, 0, 0, 0, 0, 8'hFF);
		read_txn(8'hFF, 16'hFFFF, 7'd0, 0);
		write_txn(8'h00, 16'h0000, 7'd1, 0);
		// Long hold-off while a request stream keeps the queue full.
		hold_off = 1;
		send_item(OP_START_RD, 8'hA5, 16'h5A5A, 7'd127, 0, 0);
		send_item(OP_START_WR, 8'h5A, 16'hA5A5, 7'd2, 0, 0);
		send_item(OP_DATA, 0, 0, 0, 16'h1234, 0);
		send_item(OP_START_RD, 8'h11, 16'h0102, 7'd1, 0, 0);
		send_item(OP_RX, 0, 0, 0, 0, 8'h12);
		send_item(OP_RX, 0, 0, 0, 0, 8'h04);
		send_item(OP_RX, 0, 0, 0, 0, 8'h03);
		repeat (5) send_item(OP_RX, 0, 0, 0, 0, 8'hEE);
		write_txn(8'h07, 16'h8001, 7'd3, 15);
		read_txn(8'h07, 16'h0001, 7'd2, 100);
		send_item(OP_START_RD, 8'h01, 16'h0000, 7'd1, 0, 0);
		send_item(OP_START_WR, 8'h02, 16'h0000, 7'd1, 0, 0);
		send_item(OP_DATA, 0, 0, 0, 16'hBEEF, 0);
		repeat (3) send_item(OP_RX, 0, 0, 0, 0, 8'h02);
		send_item(OP_RX, 0, 0, 0, 0, 8'h00);
		send_item(OP_RX, 0, 0, 0, 0, 8'h01);
		send_item(OP_RX, 0, 0, 0, 0, 8'h00);
		send_item(OP_RX, 0, 0, 0, 0, 8'h07);
		repeat (2) send_item(OP_RX, 0, 0, 0, 0, 8'h00);

		// Random: mostly well-formed transactions with occasional corruption.
		repeat (4) begin
			sel = $urandom_range(0, 9);
			if (sel < 4)
				read_txn(8'($urandom), 16'($urandom),
					($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 8))
					: 7'($urandom_range(1, 4)), $urandom_range(0, 1) ? 0 : 8);
			else if (sel < 8)
				write_txn(8'($urandom), 16'($urandom),
					($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 8))
					: 7'($urandom_range(1, 4)), $urandom_range(0, 1) ? 0 : 8);
			else
				repeat (4) send_item(2'($urandom), 8'($urandom), 16'($urandom),
					7'($urandom), 16'($urandom), 8'($urandom));
		end
		req.valid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (sb.pending_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("modbus_rtu_master_frame_engine_unit test passed");
		else
			$display("modbus_rtu_master_frame_engine_unit test failed");
		$finish;
	end

	initial begin
		#6000000;
		$display("modbus_rtu_master_frame_engine_unit test failed");
		$finish;
	end
endmodule
`default_nettype wire
